FILE: sv/ptts_pkg.sv
package ptts_pkg;

	localparam int DefCordicStages = 16;
	localparam int DefAngleBits    = 16;
	localparam int TableLen        = 24;

	localparam int InW    = 24;
	localparam int GuardW = 6;
	localparam int XW     = 33;
	localparam int ZW     = 34;
	localparam int OutW   = 26;

	localparam logic signed [XW-1:0] Gain = 33'sd2608131496;

	typedef struct packed {
		logic signed [InW-1:0] phasor_real;
		logic signed [InW-1:0] phasor_imag;
		logic        [31:0]    sample_time;
		logic signed [InW-1:0] dc_offset;
	} in_item_t;

	typedef struct packed {
		logic signed [OutW-1:0] sample_value;
		logic                   saturated;
	} out_item_t;

	typedef logic [31:0] cfg_word_t;

	typedef struct packed {
		logic signed [XW-1:0]  x;
		logic signed [XW-1:0]  y;
		logic signed [ZW-1:0]  z;
		logic signed [InW-1:0] dc;
	} rot_t;

	function automatic logic signed [ZW-1:0] ptts_atan(input int idx);
		logic signed [ZW-1:0] a;
		case (idx)
			0:       a = 34'sd536870912;
			1:       a = 34'sd316933406;
			2:       a = 34'sd167458907;
			3:       a = 34'sd85004756;
			4:       a = 34'sd42667331;
			5:       a = 34'sd21354465;
			6:       a = 34'sd10680862;
			7:       a = 34'sd5340245;
			8:       a = 34'sd2670675;
			9:       a = 34'sd1335343;
			10:      a = 34'sd667544;
			11:      a = 34'sd333772;
			12:      a = 34'sd166886;
			13:      a = 34'sd83443;
			14:      a = 34'sd41722;
			15:      a = 34'sd20861;
			16:      a = 34'sd10430;
			17:      a = 34'sd5215;
			18:      a = 34'sd2608;
			19:      a = 34'sd1304;
			20:      a = 34'sd652;
			21:      a = 34'sd326;
			22:      a = 34'sd163;
			23:      a = 34'sd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: sv/ptts_stream_if.sv
interface ptts_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: sv/ptts_phase.sv
module ptts_phase #(
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        freq,
	input  logic               in_valid,
	output logic               in_ready,
	input  ptts_pkg::in_item_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ptts_pkg::rot_t     out_data
);
	import ptts_pkg::*;

	localparam logic [31:0] AngMask = ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);
	localparam logic signed [ZW-1:0] Quarter = 34'sh0_4000_0000;
	localparam logic signed [ZW-1:0] Half    = 34'sh0_8000_0000;

	logic                  v_s1;
	logic [31:0]           ang_s1;
	logic signed [InW-1:0] x_s1;
	logic signed [InW-1:0] y_s1;
	logic signed [InW-1:0] dc_s1;
	logic                  v_s2;
	rot_t                  rot_s2;

	logic                  en1;
	logic                  en2;
	logic [63:0]           prod;
	logic signed [ZW-1:0]  z_d;
	logic signed [XW-1:0]  x_d;
	logic signed [XW-1:0]  y_d;
	logic                  fold;
	rot_t                  rot_d;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign prod     = 64'(freq) * 64'(in_data.sample_time);

	always_comb begin
		z_d  = ZW'(signed'(ang_s1));
		x_d  = XW'(signed'({x_s1, {GuardW{1'b0}}}));
		y_d  = XW'(signed'({y_s1, {GuardW{1'b0}}}));
		fold = (z_d > Quarter) || (z_d < -Quarter);
		rot_d.dc = dc_s1;
		if (fold) begin
			rot_d.x = -x_d;
			rot_d.y = -y_d;
			rot_d.z = z_d[ZW-1] ? z_d + Half : z_d - Half;
		end else begin
			rot_d.x = x_d;
			rot_d.y = y_d;
			rot_d.z = z_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ang_s1 <= prod[39:8] & AngMask;
			x_s1   <= in_data.phasor_real;
			y_s1   <= in_data.phasor_imag;
			dc_s1  <= in_data.dc_offset;
		end
		if (en2) begin
			rot_s2 <= rot_d;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = rot_s2;
endmodule

FILE: sv/ptts_cordic.sv
module ptts_cordic #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ptts_pkg::rot_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ptts_pkg::rot_t out_data
);
	import ptts_pkg::*;

	localparam int N = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;

	logic v_sk   [N];
	rot_t r_sk   [N];
	logic rdy    [N];
	rot_t src_d  [N];
	rot_t nxt_d  [N];

	always_comb begin
		rdy[N-1] = !v_sk[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			rdy[k] = !v_sk[k] || rdy[k+1];
		end
	end

	always_comb begin
		src_d[0] = in_data;
		for (int k = 1; k < N; k++) begin
			src_d[k] = r_sk[k-1];
		end
		for (int k = 0; k < N; k++) begin
			nxt_d[k].dc = src_d[k].dc;
			if (!src_d[k].z[ZW-1]) begin
				nxt_d[k].x = src_d[k].x - (src_d[k].y >>> k);
				nxt_d[k].y = src_d[k].y + (src_d[k].x >>> k);
				nxt_d[k].z = src_d[k].z - ptts_atan(k);
			end else begin
				nxt_d[k].x = src_d[k].x + (src_d[k].y >>> k);
				nxt_d[k].y = src_d[k].y - (src_d[k].x >>> k);
				nxt_d[k].z = src_d[k].z + ptts_atan(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				v_sk[k] <= 1'b0;
			end
		end else begin
			if (rdy[0]) begin
				v_sk[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (rdy[k]) begin
					v_sk[k] <= v_sk[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (rdy[k]) begin
				r_sk[k] <= nxt_d[k];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_sk[N-1];
	assign out_data  = r_sk[N-1];
endmodule

FILE: sv/ptts_scale.sv
module ptts_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ptts_pkg::rot_t      in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ptts_pkg::out_item_t out_data
);
	import ptts_pkg::*;

	localparam int PW = 2 * XW;
	localparam logic signed [PW-1:0] Rnd    = 66'sh0_0020_0000_0000;
	localparam logic signed [28:0]   OutMax = 29'sd33554431;
	localparam logic signed [28:0]   OutMin = -29'sd33554432;

	logic                  v_s1;
	logic signed [PW-1:0]  prod_s1;
	logic signed [InW-1:0] dc_s1;
	logic                  v_s2;
	out_item_t             res_s2;

	logic                  en1;
	logic                  en2;
	logic signed [PW-1:0]  prod_d;
	logic signed [PW-1:0]  sum_d;
	logic signed [27:0]    r_d;
	logic signed [28:0]    v_d;
	out_item_t             res_d;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign prod_d   = in_data.x * Gain;

	always_comb begin
		sum_d = prod_s1 + Rnd;
		r_d   = sum_d[PW-1:38];
		v_d   = 29'(r_d) + 29'(dc_s1);
		if (v_d > OutMax) begin
			res_d.sample_value = OutMax[OutW-1:0];
			res_d.saturated    = 1'b1;
		end else if (v_d < OutMin) begin
			res_d.sample_value = OutMin[OutW-1:0];
			res_d.saturated    = 1'b1;
		end else begin
			res_d.sample_value = v_d[OutW-1:0];
			res_d.saturated    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			prod_s1 <= prod_d;
			dc_s1   <= in_data.dc;
		end
		if (en2) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = res_s2;
endmodule

FILE: sv/phasor_to_time_sample.sv
// Channel     Dir  Transaction payload
// cfg         in   frequency, unsigned Q16.16 Hz
// sample_in   in   phasor_real, phasor_imag, sample_time, dc_offset
// sample_out  out  sample_value (signed Q10.16), saturated
//
// One transaction is accepted per cycle while the output is not stalled.
// The datapath is the CORDIC rotation pipeline, one stage per iteration (at most TableLen),
// plus two stages for the phase product and quadrant fold and two for gain and rounding.
// Reset clears the frequency register and all stage valid bits.
// A stalled output holds its data; earlier stages keep filling empty slots.
module phasor_to_time_sample #(
	parameter int CORDIC_STAGES = ptts_pkg::DefCordicStages,
	parameter int ANGLE_BITS    = ptts_pkg::DefAngleBits
) (
	input logic   clk,
	input logic   arst_n,
	ptts_stream_if.sink   cfg,
	ptts_stream_if.sink   sample_in,
	ptts_stream_if.source sample_out
);
	import ptts_pkg::*;

	logic [31:0] freq_q;
	logic        ph_valid;
	logic        ph_ready;
	rot_t        ph_data;
	logic        rot_valid;
	logic        rot_ready;
	rot_t        rot_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= '0;
		end else if (cfg.valid) begin
			freq_q <= cfg.payload;
		end
	end

	ptts_phase #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.freq      (freq_q),
		.in_valid  (sample_in.valid),
		.in_ready  (sample_in.ready),
		.in_data   (sample_in.payload),
		.out_valid (ph_valid),
		.out_ready (ph_ready),
		.out_data  (ph_data)
	);

	ptts_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ph_valid),
		.in_ready  (ph_ready),
		.in_data   (ph_data),
		.out_valid (rot_valid),
		.out_ready (rot_ready),
		.out_data  (rot_data)
	);

	ptts_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rot_valid),
		.in_ready  (rot_ready),
		.in_data   (rot_data),
		.out_valid (sample_out.valid),
		.out_ready (sample_out.ready),
		.out_data  (sample_out.payload)
	);
endmodule

FILE: test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ptts_pkg::*;

	localparam int CordicStages = DefCordicStages;
	localparam int AngleBits    = DefAngleBits;
	localparam int Latency      = CordicStages + 4;

	localparam longint QuarterTurn = 64'sd1073741824;
	localparam longint HalfTurn    = 64'sd2147483648;
	localparam longint GainQ32     = 64'sd2608131496;
	localparam longint ValueMax    = 64'sd33554431;
	localparam longint ValueMin    = -64'sd33554432;

	localparam longint AtanTurns [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10680862, 5340245, 2670675, 1335343, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	localparam logic [23:0] PosMax = 24'h7F_FFFF;
	localparam logic [23:0] NegMin = 24'h80_0000;

	class phasor_ledger;
		logic [31:0] freq;
		out_item_t   samples_due[$];
		int          errors;

		function new();
			freq   = '0;
			errors = 0;
		endfunction

		function out_item_t evaluate_phasor(in_item_t s, logic [31:0] f);
			longint      x, y, z, xs, ys, r, v;
			logic [63:0] prod;
			logic [31:0] turn;
			out_item_t   o;
			x = longint'(s.phasor_real) * 64;
			y = longint'(s.phasor_imag) * 64;
			prod = 64'(f) * 64'(s.sample_time);
			turn = 32'(prod[39 -: AngleBits]) << (32 - AngleBits);
			z = longint'($signed(turn));
			if (z > QuarterTurn || z < -QuarterTurn) begin
				x = -x;
				y = -y;
				z = (z >= 0) ? z - HalfTurn : z + HalfTurn;
			end
			for (int i = 0; i < CordicStages && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x = x - ys;
					y = y + xs;
					z = z - AtanTurns[i];
				end else begin
					x = x + ys;
					y = y - xs;
					z = z + AtanTurns[i];
				end
			end
			r = (x * GainQ32 + (64'sd1 <<< 37)) >>> 38;
			v = r + longint'(s.dc_offset);
			o.saturated = 1'b0;
			if (v > ValueMax) begin
				v = ValueMax;
				o.saturated = 1'b1;
			end else if (v < ValueMin) begin
				v = ValueMin;
				o.saturated = 1'b1;
			end
			o.sample_value = v[OutW-1:0];
			return o;
		endfunction

		function void note_input(in_item_t s);
			samples_due.push_back(evaluate_phasor(s, freq));
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (samples_due.size() == 0) begin
				report($sformatf("unexpected sample %h", got));
				return;
			end
			want = samples_due.pop_front();
			if (got.sample_value !== want.sample_value)
				report($sformatf("sample_value %0d, expected %0d",
					got.sample_value, want.sample_value));
			if (got.saturated !== want.saturated)
				report($sformatf("saturated %b, expected %b",
					got.saturated, want.saturated));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   gaps_on;
	int   stall_left;

	ptts_stream_if #(.payload_t(cfg_word_t)) cfg_if ();
	ptts_stream_if #(.payload_t(in_item_t))  in_if ();
	ptts_stream_if #(.payload_t(out_item_t)) out_if ();

	phasor_ledger sb = new();

	phasor_to_time_sample #(
		.CORDIC_STAGES(CordicStages),
		.ANGLE_BITS(AngleBits)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.sample_in(in_if),
		.sample_out(out_if)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 9) == 0) begin
			out_if.ready <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready)
			sb.check_result(out_if.payload);
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [23:0] pick_q8_16();
		case ($urandom_range(0, 9))
			0: return PosMax;
			1: return NegMin;
			2: return '0;
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic in_item_t mk(logic [23:0] x, logic [23:0] y, logic [31:0] t,
			logic [23:0] dc);
		in_item_t s;
		s.phasor_real = x;
		s.phasor_imag = y;
		s.sample_time = t;
		s.dc_offset   = dc;
		return s;
	endfunction

	task automatic send_frequency(logic [31:0] f);
		cfg_if.valid   <= 1'b1;
		cfg_if.payload <= f;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		sb.freq = f;
	endtask

	task automatic send_sample(in_item_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid   <= 1'b1;
		in_if.payload <= s;
		do @(posedge clk); while (!in_if.ready);
		sb.note_input(s);
	endtask

	task automatic drain();
		in_if.valid <= 1'b0;
		do @(posedge clk); while (sb.samples_due.size() != 0);
	endtask

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [31:0] phase_freq [6];
		arst_n         = 1'b0;
		gaps_on        = 1'b1;
		cfg_if.valid   = 1'b0;
		cfg_if.payload = '0;
		in_if.valid    = 1'b0;
		in_if.payload  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(mk(PosMax, '0, '0, '0));
		send_sample(mk(NegMin, '0, '0, '0));
		send_sample(mk(PosMax, PosMax, '0, PosMax));
		send_sample(mk(NegMin, NegMin, '1, NegMin));
		send_sample(mk('0, '0, '0, '0));
		drain();

		send_frequency(32'h0001_0000);
		send_sample(mk(PosMax, NegMin, 32'h0000_0000, '0));
		send_sample(mk(PosMax, NegMin, 32'h0040_0000, '0));
		send_sample(mk(NegMin, PosMax, 32'h0040_0100, PosMax));
		send_sample(mk(PosMax, PosMax, 32'h0080_0000, NegMin));
		send_sample(mk(NegMin, NegMin, 32'h00C0_0000, '0));
		send_sample(mk(PosMax, '0, 32'h00BF_FF00, '1));
		send_sample(mk('1, '1, '1, '1));
		drain();

		send_frequency('1);
		send_sample(mk(PosMax, PosMax, '1, PosMax));
		send_sample(mk(NegMin, NegMin, '1, NegMin));
		send_sample(mk(NegMin, PosMax, 32'h0000_0001, '0));
		drain();

		phase_freq = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h003C_0000, $urandom(),
			$urandom(), 32'h0000_0000};
		for (int p = 0; p < 6; p++) begin
			gaps_on = (p != 3);
			send_frequency(phase_freq[p]);
			for (int n = 0; n < 65; n++)
				send_sample(mk(pick_q8_16(), pick_q8_16(), pick_time(), pick_q8_16()));
			drain();
		end

		repeat (Latency + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

FILE: sim.f
sv/ptts_pkg.sv
sv/ptts_stream_if.sv
sv/ptts_phase.sv
sv/ptts_cordic.sv
sv/ptts_scale.sv
sv/phasor_to_time_sample.sv
test/tb.sv
